[rtl/cdtsd_pkg.sv]
package cdtsd_pkg;

   localparam int FRAME_BITS = 8;
   localparam int POS_W = $clog2(FRAME_BITS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam int MINUTE_SECONDS = 60;
   localparam int QUARTER_SECONDS = 15;
   localparam logic [5:0] SECONDS_MAX = 6'(MINUTE_SECONDS - 1);

   localparam logic [1:0] CMD_SET = 2'd0;
   localparam logic [1:0] CMD_TICK = 2'd1;
   localparam logic [1:0] CMD_ON = 2'd2;
   localparam logic [1:0] CMD_OFF = 2'd3;

   typedef struct packed {
      logic [1:0] command;
      logic [3:0] minutes;
      logic [5:0] seconds;
   } req_type;

   typedef struct packed {
      logic [9:0] remaining_seconds;
      logic       serial_bit;
      logic       bit_valid;
      logic       latch_strobe;
      logic       display_enable_n;
   } rsp_type;

   typedef struct packed {
      logic [9:0]            remaining_seconds;
      logic [FRAME_BITS-1:0] frame;
      logic                  refresh;
      logic                  enable_n;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } qstat_type;

   function automatic logic [1:0] quarter_of(input logic [5:0] secs);
      logic [1:0] q;
      if (secs >= 6'(3 * QUARTER_SECONDS)) begin
         q = 2'd3;
      end else if (secs >= 6'(2 * QUARTER_SECONDS)) begin
         q = 2'd2;
      end else if (secs >= 6'(QUARTER_SECONDS)) begin
         q = 2'd1;
      end else begin
         q = 2'd0;
      end
      return q;
   endfunction

endpackage

[rtl/countdown_timer_serial_display_top.sv]
// Countdown timer with a serially shifted display byte. A set command loads
// minutes*60+seconds (seconds above 59 clamp to 59); a tick lowers the count
// and stops at zero. Each set, and each tick that changes the count, yields
// eight transfers carrying the display byte MSB first, the last with
// latch_strobe; every other command yields one transfer with bit_valid low.
// A request is accepted while the queue is not full and parked in a
// four-entry queue; the serializer then drives one result transfer per
// cycle while rsp_stall does not hold the output, and it takes the next
// queued item only after the last transfer of the current one.
module countdown_timer_serial_display_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  cdtsd_pkg::req_type req,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cdtsd_pkg::rsp_type rsp
);
   import cdtsd_pkg::*;

   qstat_type qstat;
   entry_type push_entry;
   entry_type head;
   logic      push;
   logic      pop;

   cdtsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   cdtsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   cdtsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

[rtl/cdtsd_front.sv]
module cdtsd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cdtsd_pkg::req_type  req,
   input  cdtsd_pkg::qstat_type qstat,
   output logic                push,
   output cdtsd_pkg::entry_type push_entry
);
   import cdtsd_pkg::*;

   logic [9:0] count_ff, count_in;
   logic [3:0] mins_ff, mins_in;
   logic [5:0] secs_ff, secs_in;
   logic       enable_n_ff, enable_n_in;
   logic       refresh;
   logic [5:0] secs_sat;

   assign req_stall = qstat.full;
   assign push = req_valid && !qstat.full;

   always_comb begin
      count_in = count_ff;
      mins_in = mins_ff;
      secs_in = secs_ff;
      enable_n_in = enable_n_ff;
      refresh = 1'b0;
      secs_sat = (req.seconds > SECONDS_MAX) ? SECONDS_MAX : req.seconds;
      case (req.command)
         CMD_SET: begin
            mins_in = req.minutes;
            secs_in = secs_sat;
            count_in = 10'(req.minutes) * 10'(MINUTE_SECONDS) + 10'(secs_sat);
            refresh = 1'b1;
         end
         CMD_TICK: begin
            if (count_ff != 10'd0) begin
               count_in = count_ff - 10'd1;
               refresh = 1'b1;
               if (secs_ff == 6'd0) begin
                  secs_in = SECONDS_MAX;
                  mins_in = mins_ff - 4'd1;
               end else begin
                  secs_in = secs_ff - 6'd1;
               end
            end
         end
         CMD_ON: begin
            enable_n_in = 1'b0;
         end
         default: begin
            enable_n_in = 1'b1;
         end
      endcase
   end

   always_comb begin
      push_entry.remaining_seconds = count_in;
      push_entry.frame = FRAME_BITS'({quarter_of(secs_in), mins_in});
      push_entry.refresh = refresh;
      push_entry.enable_n = enable_n_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mins_ff <= '0;
         secs_ff <= '0;
         enable_n_ff <= 1'b0;
      end else if (push) begin
         count_ff <= count_in;
         mins_ff <= mins_in;
         secs_ff <= secs_in;
         enable_n_ff <= enable_n_in;
      end
   end

endmodule

[rtl/cdtsd_queue.sv]
module cdtsd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cdtsd_pkg::entry_type push_entry,
   input  logic                 pop,
   output cdtsd_pkg::entry_type head,
   output cdtsd_pkg::qstat_type qstat
);
   import cdtsd_pkg::*;

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     fill_ff, fill_in;

   assign head = slot_ff[rd_ptr_ff];
   assign qstat.full = (fill_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign qstat.not_empty = (fill_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

[rtl/cdtsd_back.sv]
module cdtsd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  cdtsd_pkg::entry_type head,
   input  cdtsd_pkg::qstat_type qstat,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cdtsd_pkg::rsp_type   rsp
);
   import cdtsd_pkg::*;

   entry_type        ent_ff, ent_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             advance;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   always_comb begin
      pop = 1'b0;
      ent_in = ent_ff;
      pos_in = pos_ff;
      busy_in = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b0;
         if (busy_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in.remaining_seconds = ent_ff.remaining_seconds;
            rsp_in.serial_bit = ent_ff.frame[pos_ff];
            rsp_in.bit_valid = 1'b1;
            rsp_in.latch_strobe = (pos_ff == '0);
            rsp_in.display_enable_n = ent_ff.enable_n;
            pos_in = pos_ff - 1'b1;
            busy_in = (pos_ff != '0);
         end else if (qstat.not_empty) begin
            pop = 1'b1;
            rsp_valid_in = 1'b1;
            ent_in = head;
            rsp_in.remaining_seconds = head.remaining_seconds;
            rsp_in.display_enable_n = head.enable_n;
            if (head.refresh) begin
               rsp_in.serial_bit = head.frame[FRAME_BITS-1];
               rsp_in.bit_valid = 1'b1;
               rsp_in.latch_strobe = 1'b0;
               pos_in = POS_W'(FRAME_BITS - 2);
               busy_in = 1'b1;
            end else begin
               rsp_in.serial_bit = 1'b0;
               rsp_in.bit_valid = 1'b0;
               rsp_in.latch_strobe = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      rsp_ff <= rsp_in;
      pos_ff <= pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/cdtsd_checker.sv]
module cdtsd_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input cdtsd_pkg::rsp_type rsp
);
   import cdtsd_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result changed");

   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.latch_strobe |-> rsp.bit_valid)
      else $error("latch strobe outside a refresh");

   a_idle_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.bit_valid |-> !rsp.serial_bit && !rsp.latch_strobe)
      else $error("serial bit set without refresh");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.remaining_seconds <= 10'd959)
      else $error("remaining seconds out of range");

endmodule

bind countdown_timer_serial_display_top cdtsd_checker u_cdtsd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);
